// ===== rtl/otce_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle table clearance evaluator - shared definitions
// Types, codes and fixed widths used across the obstacle table datapath.
// ----------------------------------------------------------------------------
package otce_pkg;

   // default sizing
   localparam int MAX_OBSTACLES_DEF   = 64;
   localparam int COORD_FRAC_BITS_DEF = 16;

   // fixed datapath widths
   localparam int TRIG_FRAC = 14;   // Q1.14 cos/sin
   localparam int DIFF_W    = 33;   // point minus center
   localparam int MUL_W     = 33;   // shared multiplier operand
   localparam int PROD_W    = 66;   // shared multiplier product
   localparam int ROT_W     = 51;   // rotated sum before the Q1.14 shift
   localparam int MAG_W     = 35;   // magnitude of a rotated coordinate
   localparam int DIV_W     = 32;   // divisor width
   localparam int QUO_W     = 31;   // quotient bits kept, more is overflow

   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_UPDATE = 2'd1,
      OP_DELETE = 2'd2,
      OP_EVAL   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUP_ID    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic {
      CSR_ROBOT_WIDTH  = 1'b0,
      CSR_ROBOT_LENGTH = 1'b1
   } csr_addr_type;

   typedef struct packed {
      op_type             op;
      logic [15:0]        obstacle_id;
      logic               shape_kind;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        extent_a;
      logic [30:0]        extent_b;
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
      logic [5:0]         slot_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] eq_value;
      logic               value_saturated;
      logic [6:0]         obstacle_count;
   } rsp_type;

   // one table row as stored in the entry RAM
   typedef struct packed {
      logic [15:0]        id;
      logic               kind;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        extent_a;
      logic [30:0]        extent_b;
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_ACT,
      S_SH_RD,
      S_SH_WR,
      S_EV_RD,
      S_EV_LD,
      S_EV_WAIT,
      S_RESP
   } ctl_state_type;

   typedef enum logic [4:0] {
      EV_IDLE,
      EV_DIFF,
      EV_ROT0,
      EV_ROT1,
      EV_ROT2,
      EV_ROT3,
      EV_ROT4,
      EV_DSA,
      EV_WA,
      EV_DSB,
      EV_WB,
      EV_CHK,
      EV_SQ0,
      EV_SQ1,
      EV_SQ2,
      EV_RECT,
      EV_DONE
   } eval_state_type;

   function automatic entry_type entry_from_req(req_type r);
      entry_type e;
      e.id       = r.obstacle_id;
      e.kind     = r.shape_kind;
      e.center_x = r.center_x;
      e.center_y = r.center_y;
      e.extent_a = r.extent_a;
      e.extent_b = r.extent_b;
      e.cos_yaw  = r.cos_yaw;
      e.sin_yaw  = r.sin_yaw;
      return e;
   endfunction

endpackage

// ===== rtl/otce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module otce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/otce_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned, one quotient bit per cycle. Keeps the low quotient bits and
// flags any higher quotient bit as overflow.
// ----------------------------------------------------------------------------
module otce_div import otce_pkg::*; #(
   parameter int NUM_W = MAG_W + COORD_FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DIV_W-1:0] den_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic             ovf_ff;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             ge;

   // trial subtract of the next dividend bit
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         ovf_ff <= ovf_ff | quo_ff[QUO_W-1];
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign ovf  = ovf_ff;

endmodule

// ===== rtl/otce_eval.sv =====
// ----------------------------------------------------------------------------
// Clearance evaluation unit
// Rotates a query point into an obstacle frame on a shared multiplier,
// divides by the inflated extents and forms the implicit value.
// ----------------------------------------------------------------------------
module otce_eval import otce_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  entry_type          entry,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic [30:0]        robot_width,
   input  logic [30:0]        robot_length,
   output logic               done,
   output logic signed [31:0] value,
   output logic               saturated
);

   localparam int          NUM_W = MAG_W + COORD_FRAC_BITS;
   localparam logic [63:0] ONE   = 64'd1 << COORD_FRAC_BITS;

   eval_state_type state_ff, state_in;

   entry_type                 ent_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ROT_W-1:0]   acc_ff, su_ff, sv_ff;
   logic [QUO_W-1:0]          qa_ff, qb_ff;
   logic                      ova_ff, ovb_ff;
   logic [63:0]               ta_ff;
   logic signed [31:0]        value_ff;
   logic                      sat_ff;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [ROT_W-1:0]   u_sh, v_sh, u_abs, v_abs;
   logic [DIV_W-1:0]          ra, rb, pa, pb, da, db;
   logic [DIV_W-1:0]          sum_a, sum_b;
   logic                      div_start, div_done, div_ovf;
   logic [NUM_W-1:0]          div_num;
   logic [DIV_W-1:0]          div_den;
   logic [QUO_W-1:0]          div_quo, q_max;
   logic [63:0]               sq_term, ell_sum;
   logic signed [33:0]        rect_val;

   // divisors: ellipse radius plus half robot, or half of (size plus robot)
   assign ra    = {1'b0, ent_ff.extent_a} + {2'b00, robot_width[30:1]};
   assign rb    = {1'b0, ent_ff.extent_b} + {2'b00, robot_length[30:1]};
   assign sum_a = {1'b0, ent_ff.extent_a} + {1'b0, robot_width};
   assign sum_b = {1'b0, ent_ff.extent_b} + {1'b0, robot_length};
   assign pa    = {1'b0, sum_a[DIV_W-1:1]};
   assign pb    = {1'b0, sum_b[DIV_W-1:1]};
   assign da    = ent_ff.kind ? pa : ra;
   assign db    = ent_ff.kind ? pb : rb;

   // floor shift of the rotated sums and their magnitudes
   assign u_sh  = su_ff >>> TRIG_FRAC;
   assign v_sh  = sv_ff >>> TRIG_FRAC;
   assign u_abs = u_sh[ROT_W-1] ? -u_sh : u_sh;
   assign v_abs = v_sh[ROT_W-1] ? -v_sh : v_sh;

   assign div_num = (state_ff == EV_DSA) ?
                    {u_abs[MAG_W-1:0], {COORD_FRAC_BITS{1'b0}}} :
                    {v_abs[MAG_W-1:0], {COORD_FRAC_BITS{1'b0}}};
   assign div_den = (state_ff == EV_DSA) ? da : db;

   // squared quotient term and the two result forms
   assign sq_term  = 64'(unsigned'(prod_ff) >> COORD_FRAC_BITS);
   assign ell_sum  = ta_ff + sq_term;
   assign q_max    = (qa_ff > qb_ff) ? qa_ff : qb_ff;
   assign rect_val = signed'({2'b00, q_max, 1'b0}) - signed'(34'(ONE << 1));

   otce_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EV_IDLE: if (start) state_in = EV_DIFF;
         EV_DIFF: state_in = EV_ROT0;
         EV_ROT0: state_in = EV_ROT1;
         EV_ROT1: state_in = EV_ROT2;
         EV_ROT2: state_in = EV_ROT3;
         EV_ROT3: state_in = EV_ROT4;
         EV_ROT4: begin
            if (da == '0 || db == '0) state_in = EV_DONE;
            else                      state_in = EV_DSA;
         end
         EV_DSA: state_in = EV_WA;
         EV_WA: if (div_done) state_in = EV_DSB;
         EV_DSB: state_in = EV_WB;
         EV_WB: if (div_done) state_in = EV_CHK;
         EV_CHK: begin
            if (ova_ff || ovb_ff) state_in = EV_DONE;
            else if (ent_ff.kind) state_in = EV_RECT;
            else                  state_in = EV_SQ0;
         end
         EV_SQ0:  state_in = EV_SQ1;
         EV_SQ1:  state_in = EV_SQ2;
         EV_SQ2:  state_in = EV_DONE;
         EV_RECT: state_in = EV_DONE;
         EV_DONE: state_in = EV_IDLE;
         default: state_in = EV_IDLE;
      endcase
   end

   // outputs: multiplier operands and divider start
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      unique case (state_ff)
         EV_ROT0: begin
            mul_a = dx_ff;
            mul_b = {{(MUL_W-16){ent_ff.cos_yaw[15]}}, ent_ff.cos_yaw};
         end
         EV_ROT1: begin
            mul_a = dy_ff;
            mul_b = {{(MUL_W-16){ent_ff.sin_yaw[15]}}, ent_ff.sin_yaw};
         end
         EV_ROT2: begin
            mul_a = dy_ff;
            mul_b = {{(MUL_W-16){ent_ff.cos_yaw[15]}}, ent_ff.cos_yaw};
         end
         EV_ROT3: begin
            mul_a = dx_ff;
            mul_b = {{(MUL_W-16){ent_ff.sin_yaw[15]}}, ent_ff.sin_yaw};
         end
         EV_SQ0: begin
            mul_a = {2'b00, qa_ff};
            mul_b = {2'b00, qa_ff};
         end
         EV_SQ1: begin
            mul_a = {2'b00, qb_ff};
            mul_b = {2'b00, qb_ff};
         end
         EV_DSA, EV_DSB: div_start = 1'b1;
         default: ;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         EV_IDLE: begin
            if (start) ent_ff <= entry;
         end
         EV_DIFF: begin
            dx_ff <= {point_x[31], point_x} - {ent_ff.center_x[31], ent_ff.center_x};
            dy_ff <= {point_y[31], point_y} - {ent_ff.center_y[31], ent_ff.center_y};
         end
         EV_ROT1: acc_ff <= ROT_W'(prod_ff);
         EV_ROT2: su_ff  <= acc_ff + ROT_W'(prod_ff);
         EV_ROT3: acc_ff <= ROT_W'(prod_ff);
         EV_ROT4: begin
            sv_ff <= acc_ff - ROT_W'(prod_ff);
            if (da == '0 || db == '0) begin
               value_ff <= VALUE_MAX;
               sat_ff   <= 1'b1;
            end
         end
         EV_WA: begin
            if (div_done) begin
               qa_ff  <= div_quo;
               ova_ff <= div_ovf;
            end
         end
         EV_WB: begin
            if (div_done) begin
               qb_ff  <= div_quo;
               ovb_ff <= div_ovf;
            end
         end
         EV_CHK: begin
            if (ova_ff || ovb_ff) begin
               value_ff <= VALUE_MAX;
               sat_ff   <= 1'b1;
            end
         end
         EV_SQ1: ta_ff <= sq_term;
         EV_SQ2: begin
            if (ell_sum > (64'(VALUE_MAX) + ONE)) begin
               value_ff <= VALUE_MAX;
               sat_ff   <= 1'b1;
            end else begin
               value_ff <= 32'(ell_sum - ONE);
               sat_ff   <= 1'b0;
            end
         end
         EV_RECT: begin
            if (rect_val > 34'sd2147483647) begin
               value_ff <= VALUE_MAX;
               sat_ff   <= 1'b1;
            end else begin
               value_ff <= rect_val[31:0];
               sat_ff   <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign done      = (state_ff == EV_DONE);
   assign value     = value_ff;
   assign saturated = sat_ff;

endmodule

// ===== rtl/obstacle_table_clearance_eval.sv =====
// ----------------------------------------------------------------------------
// Obstacle table clearance evaluator - top level
// Ordered obstacle table in a single-port-read entry RAM, with id search,
// add, update, delete with shift-down, and point clearance evaluation.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; each produces exactly one response.
// Add, update and delete search the table one entry per cycle; a delete then
// moves every later entry down, through one read state and one write state
// per entry. Evaluate runs the bit-serial divider twice per point, and a bad
// slot skips evaluation and answers directly. The response sits in an output
// register, so the next request is taken while an earlier response still
// waits. Entries read back only after they were written; there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module obstacle_table_clearance_eval import otce_pkg::*; #(
   parameter int MAX_OBSTACLES   = MAX_OBSTACLES_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         csr_we,
   input  csr_addr_type csr_addr,
   input  logic [30:0]  csr_wdata
);

   localparam int AW      = $clog2(MAX_OBSTACLES);
   localparam int CNT_W   = $clog2(MAX_OBSTACLES + 1);
   localparam int ENTRY_W = $bits(entry_type);

   ctl_state_type state_ff, state_in;

   req_type            req_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff;
   logic               found_ff;
   logic [CNT_W-1:0]   slot_ff;
   status_type         status_ff;
   logic signed [31:0] value_ff;
   logic               sat_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [30:0]        robot_width_ff;
   logic [30:0]        robot_length_ff;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   entry_type          ram_wdata, rdata;
   logic [ENTRY_W-1:0] ram_rdata;

   logic               accept, hit, srch_more, full, slot_bad, sh_more, rsp_free;
   logic [CNT_W-1:0]   sh_next;
   logic               ev_start, ev_done, ev_sat;
   logic signed [31:0] ev_value;

   assign rdata     = entry_type'(ram_rdata);
   assign accept    = req_valid && req_ready;
   assign hit       = rd_vld_ff && (rdata.id == req_ff.obstacle_id);
   assign srch_more = (idx_ff < count_ff);
   assign full      = (count_ff >= CNT_W'(MAX_OBSTACLES));
   assign slot_bad  = ({{CNT_W{1'b0}}, req_data.slot_index} >= {6'b0, count_ff});
   assign sh_next   = slot_ff + 1'b1;
   assign sh_more   = (sh_next < count_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   otce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_OBSTACLES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   otce_eval #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_eval (
      .clock        (clock),
      .reset        (reset),
      .start        (ev_start),
      .entry        (rdata),
      .point_x      (req_ff.point_x),
      .point_y      (req_ff.point_y),
      .robot_width  (robot_width_ff),
      .robot_length (robot_length_ff),
      .done         (ev_done),
      .value        (ev_value),
      .saturated    (ev_sat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_EVAL) state_in = slot_bad ? S_RESP : S_EV_RD;
               else                         state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (hit || (!srch_more && !rd_vld_ff)) state_in = S_ACT;
         end
         S_ACT: begin
            if (req_ff.op == OP_DELETE && found_ff) state_in = S_SH_RD;
            else                                     state_in = S_RESP;
         end
         S_SH_RD:   state_in = sh_more ? S_SH_WR : S_RESP;
         S_SH_WR:   state_in = S_SH_RD;
         S_EV_RD:   state_in = S_EV_LD;
         S_EV_LD:   state_in = S_EV_WAIT;
         S_EV_WAIT: if (ev_done) state_in = S_RESP;
         S_RESP:    if (rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs: RAM port control and evaluation start
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = slot_ff[AW-1:0];
      ram_wdata = entry_from_req(req_ff);
      ram_raddr = idx_ff[AW-1:0];
      ev_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_ACT: begin
            if (req_ff.op == OP_ADD && !found_ff && !full) begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[AW-1:0];
            end else if (req_ff.op == OP_UPDATE && found_ff) begin
               ram_we = 1'b1;
            end
         end
         S_SH_RD: ram_raddr = sh_next[AW-1:0];
         S_SH_WR: begin
            ram_we    = 1'b1;
            ram_wdata = rdata;
         end
         S_EV_RD: ram_raddr = AW'(req_ff.slot_index);
         S_EV_LD: ev_start = 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         robot_width_ff  <= '0;
         robot_length_ff <= '0;
      end else begin
         state_ff <= state_in;

         // configuration writes
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ROBOT_WIDTH:  robot_width_ff  <= csr_wdata;
               CSR_ROBOT_LENGTH: robot_length_ff <= csr_wdata;
            endcase
         end

         // search read pipeline
         if (state_ff == S_SEARCH) rd_vld_ff <= srch_more && !hit;
         else                      rd_vld_ff <= 1'b0;

         // table occupancy
         if (state_ff == S_ACT && req_ff.op == OP_ADD && !found_ff && !full) begin
            count_ff <= count_ff + 1'b1;
         end else if (state_ff == S_SH_RD && !sh_more) begin
            count_ff <= count_ff - 1'b1;
         end

         // response register
         if (state_ff == S_RESP && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                 rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_ff   <= req_data;
               idx_ff   <= '0;
               found_ff <= 1'b0;
               value_ff <= '0;
               sat_ff   <= 1'b0;
               status_ff <= (req_data.op == OP_EVAL && slot_bad) ? ST_BAD_INDEX : ST_OK;
            end
         end
         S_SEARCH: begin
            if (hit) begin
               found_ff <= 1'b1;
               slot_ff  <= rd_idx_ff;
            end else if (srch_more) begin
               rd_idx_ff <= idx_ff;
               idx_ff    <= idx_ff + 1'b1;
            end
         end
         S_ACT: begin
            case (req_ff.op)
               OP_ADD: begin
                  if (found_ff)  status_ff <= ST_DUP_ID;
                  else if (full) status_ff <= ST_FULL;
               end
               OP_UPDATE, OP_DELETE: begin
                  if (!found_ff) status_ff <= ST_NOT_FOUND;
               end
               default: ;
            endcase
         end
         S_SH_WR: slot_ff <= sh_next;
         S_EV_WAIT: begin
            if (ev_done) begin
               value_ff <= ev_value;
               sat_ff   <= ev_sat;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_ff.status          <= status_ff;
               rsp_ff.eq_value        <= value_ff;
               rsp_ff.value_saturated <= sat_ff;
               rsp_ff.obstacle_count  <= 7'(count_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // table never holds more than its capacity
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_OBSTACLES))
      else $error("entry count above capacity");

   // one transaction moves the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) ||
                count_ff == $past(count_ff) + 1'b1 ||
                count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped");

   // evaluation finishes only while the sequencer waits for it
   a_ev_done_wait: assert property (@(posedge clock) disable iff (reset)
      ev_done |-> state_ff == S_EV_WAIT)
      else $error("stray evaluation done");

   // no second request is taken while one is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while busy");

endmodule
